// ----- sv/lsse_pkg.sv -----
// Package for the load/store/stack executor: payload types, command codes
// and register indexes. No dependencies.
package lsse_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [2:0] IX_B = 3'd0;
    localparam logic [2:0] IX_C = 3'd1;
    localparam logic [2:0] IX_D = 3'd2;
    localparam logic [2:0] IX_E = 3'd3;
    localparam logic [2:0] IX_H = 3'd4;
    localparam logic [2:0] IX_L = 3'd5;
    localparam logic [2:0] IX_F = 3'd6;
    localparam logic [2:0] IX_A = 3'd7;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_in;

    typedef struct packed {
        logic        illegal_opcode;
        logic [7:0]  read_data;
        logic [15:0] pc;
        logic [15:0] sp;
        logic [15:0] reg_af;
        logic [15:0] reg_bc;
        logic [15:0] reg_de;
        logic [15:0] reg_hl;
    } t_out;

    // Memory port request from the sequencer to the byte RAM.
    typedef struct packed {
        logic        en;
        logic        we;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } t_mem_req;

endpackage

// ----- sv/lsse_ram.sv -----
// 64 KiB single-port byte RAM; the read data is registered.
// Depends on lsse_pkg for the request struct.
module lsse_ram (
    input  logic              i_clk,
    input  lsse_pkg::t_mem_req i_req,
    output logic [7:0]        o_rdata
);
    import lsse_pkg::*;

    logic [7:0] mem [0:65535];

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.we) begin
                mem[i_req.addr] <= i_req.wdata;
            end
            o_rdata <= mem[i_req.addr];
        end
    end
endmodule

// ----- sv/cpu_load_store_stack_executor_top.sv -----
// Load/store/stack executor top level. Host commands (write byte, read byte,
// execute the instruction at PC) act on an internal 64 KiB byte memory with a
// single port. A host write completes when it is accepted and a host read
// when the RAM returns its data. An instruction fetches its opcode, then each
// operand byte, then makes its data accesses in S_MEM, S_MEM2 and, for a pop,
// S_MEM3: an unsupported opcode ends after the opcode fetch and register-only
// forms end in S_MEM. One result is returned per transfer, held in an output
// register; while that result waits under a receiver stall the input stalls.
// Depends on lsse_pkg and lsse_ram.
module cpu_load_store_stack_executor_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lsse_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output lsse_pkg::t_out o_data
);
    import lsse_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OP   = 7'b0000010,
        S_B1   = 7'b0000100,
        S_B2   = 7'b0001000,
        S_MEM  = 7'b0010000,
        S_MEM2 = 7'b0100000,
        S_MEM3 = 7'b1000000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_pc, n_pc, r_sp, n_sp;
    logic [7:0]  r_rf [0:7];
    logic [7:0]  n_rf [0:7];
    logic [7:0]  r_op, n_op, r_b1, n_b1, r_b2, n_b2;
    logic        r_hostrd, n_hostrd;
    logic        r_ov, n_ov;
    t_out        r_out, n_out;
    t_mem_req    w_req;
    logic [7:0]  w_rdata;
    logic        w_done, w_ill;
    logic [7:0]  w_rd;

    lsse_ram u_ram (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    wire w_out_free = !r_ov || !i_stall;
    assign o_stall = !(r_state == S_IDLE && !r_hostrd) || !w_out_free;
    wire w_acc = i_valid && !o_stall;

    wire [15:0] w_hl = {r_rf[IX_H], r_rf[IX_L]};
    wire [15:0] w_bc = {r_rf[IX_B], r_rf[IX_C]};
    wire [15:0] w_de = {r_rf[IX_D], r_rf[IX_E]};

    // Number of operand bytes after the opcode (0..2).
    function automatic logic [1:0] f_ops(input logic [7:0] op);
        if ((op & 8'hC7) == 8'h06) return 2'd1;
        case (op)
            8'hFA, 8'hEA, 8'h01, 8'h11, 8'h21, 8'h31, 8'h08: return 2'd2;
            8'hF0, 8'hE0, 8'hF8: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic f_legal(input logic [7:0] op);
        if (op inside {[8'h40:8'h7F]}) return op != 8'h76;
        if ((op & 8'hC7) == 8'h06) return 1'b1;
        case (op)
            8'h0A, 8'h1A, 8'hFA, 8'h02, 8'h12, 8'hEA, 8'h01, 8'h11, 8'h21,
            8'h31, 8'hF2, 8'hE2, 8'hF0, 8'hE0, 8'h3A, 8'h32, 8'h2A, 8'h22,
            8'hF8, 8'hF9, 8'h08, 8'hF5, 8'hC5, 8'hD5, 8'hE5, 8'hF1, 8'hC1,
            8'hD1, 8'hE1, 8'h87: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    always_comb begin
        logic [7:0]  op, b1, b2, src;
        logic [15:0] nn, t;
        logic [2:0]  dst;
        op = r_op; b1 = r_b1; b2 = r_b2; nn = {r_b2, r_b1};
        src = 8'd0; dst = 3'd0; t = 16'd0;
        n_state = r_state; n_pc = r_pc; n_sp = r_sp; n_op = r_op;
        n_b1 = r_b1; n_b2 = r_b2; n_hostrd = 1'b0;
        for (int k = 0; k < 8; k++) n_rf[k] = r_rf[k];
        w_req = '{en: 1'b0, we: 1'b0, addr: 16'd0, wdata: 8'd0};
        w_done = 1'b0; w_ill = 1'b0; w_rd = 8'd0;

        if (r_hostrd) begin
            w_done = 1'b1; w_rd = w_rdata;
        end
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_data.cmd)
                        CMD_WRITE: begin
                            w_req = '{1'b1, 1'b1, i_data.addr, i_data.data};
                            w_done = 1'b1;
                        end
                        CMD_READ: begin
                            w_req = '{1'b1, 1'b0, i_data.addr, 8'd0};
                            n_hostrd = 1'b1;
                        end
                        CMD_EXEC: begin
                            w_req = '{1'b1, 1'b0, r_pc, 8'd0};
                            n_state = S_OP;
                        end
                        default: w_done = 1'b1;
                    endcase
                end
            end
            S_OP: begin
                op = w_rdata; n_op = w_rdata;
                if (!f_legal(op)) begin
                    w_ill = 1'b1; w_done = 1'b1; n_state = S_IDLE;
                end else if (f_ops(op) != 2'd0) begin
                    w_req = '{1'b1, 1'b0, r_pc + 16'd1, 8'd0};
                    n_state = S_B1;
                end else begin
                    n_state = S_MEM;
                end
            end
            S_B1: begin
                n_b1 = w_rdata;
                if (f_ops(op) == 2'd2) begin
                    w_req = '{1'b1, 1'b0, r_pc + 16'd2, 8'd0};
                    n_state = S_B2;
                end else begin
                    n_state = S_MEM;
                end
            end
            S_B2: begin
                n_b2 = w_rdata;
                n_state = S_MEM;
            end
            // First data access of the instruction; register-only forms end here.
            S_MEM: begin
                n_state = S_MEM2;
                if (op inside {[8'h40:8'h7F]}) begin
                    if (op[2:0] == 3'd6)
                        w_req = '{1'b1, 1'b0, w_hl, 8'd0};
                    else if (op[5:3] == 3'd6)
                        w_req = '{1'b1, 1'b1, w_hl, r_rf[op[2:0]]};
                    else begin
                        n_rf[op[5:3]] = r_rf[op[2:0]]; n_state = S_IDLE;
                    end
                end else if ((op & 8'hC7) == 8'h06) begin
                    if (op[5:3] == 3'd6) w_req = '{1'b1, 1'b1, w_hl, b1};
                    else n_rf[op[5:3]] = b1;
                    n_state = S_IDLE;
                end else begin
                    case (op)
                        8'h0A: w_req = '{1'b1, 1'b0, w_bc, 8'd0};
                        8'h1A: w_req = '{1'b1, 1'b0, w_de, 8'd0};
                        8'hFA: w_req = '{1'b1, 1'b0, nn, 8'd0};
                        8'hF2: w_req = '{1'b1, 1'b0, HIGH_PAGE | {8'd0, r_rf[IX_C]}, 8'd0};
                        8'hF0: w_req = '{1'b1, 1'b0, HIGH_PAGE | {8'd0, b1}, 8'd0};
                        8'h3A, 8'h2A: w_req = '{1'b1, 1'b0, w_hl, 8'd0};
                        8'hF1, 8'hC1, 8'hD1, 8'hE1:
                            w_req = '{1'b1, 1'b0, r_sp, 8'd0};
                        8'h02: w_req = '{1'b1, 1'b1, w_bc, r_rf[IX_A]};
                        8'h12: w_req = '{1'b1, 1'b1, w_de, r_rf[IX_A]};
                        8'hEA: w_req = '{1'b1, 1'b1, nn, r_rf[IX_A]};
                        8'hE2: w_req = '{1'b1, 1'b1, HIGH_PAGE | {8'd0, r_rf[IX_C]},
                                         r_rf[IX_A]};
                        8'hE0: w_req = '{1'b1, 1'b1, HIGH_PAGE | {8'd0, b1}, r_rf[IX_A]};
                        8'h32, 8'h22: w_req = '{1'b1, 1'b1, w_hl, r_rf[IX_A]};
                        8'h08: w_req = '{1'b1, 1'b1, nn, r_sp[7:0]};
                        8'hF5: w_req = '{1'b1, 1'b1, r_sp - 16'd1, r_rf[IX_A]};
                        8'hC5: w_req = '{1'b1, 1'b1, r_sp - 16'd1, r_rf[IX_B]};
                        8'hD5: w_req = '{1'b1, 1'b1, r_sp - 16'd1, r_rf[IX_D]};
                        8'hE5: w_req = '{1'b1, 1'b1, r_sp - 16'd1, r_rf[IX_H]};
                        8'h01: begin n_rf[IX_B] = b2; n_rf[IX_C] = b1; n_state = S_IDLE; end
                        8'h11: begin n_rf[IX_D] = b2; n_rf[IX_E] = b1; n_state = S_IDLE; end
                        8'h21: begin n_rf[IX_H] = b2; n_rf[IX_L] = b1; n_state = S_IDLE; end
                        8'h31: begin n_sp = nn; n_state = S_IDLE; end
                        8'hF9: begin n_sp = w_hl; n_state = S_IDLE; end
                        8'hF8: begin
                            t = r_sp + {{8{b1[7]}}, b1};
                            n_rf[IX_H] = t[15:8]; n_rf[IX_L] = t[7:0];
                            n_state = S_IDLE;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            // Uses the read data of S_MEM and makes the second access if any.
            S_MEM2: begin
                n_state = S_IDLE;
                if (op inside {[8'h40:8'h7F]}) begin
                    if (op[2:0] == 3'd6) n_rf[op[5:3]] = w_rdata;
                end else begin
                    case (op)
                        8'h0A, 8'h1A, 8'hFA, 8'hF2, 8'hF0: n_rf[IX_A] = w_rdata;
                        8'h3A: begin
                            n_rf[IX_A] = w_rdata; t = w_hl - 16'd1;
                            n_rf[IX_H] = t[15:8]; n_rf[IX_L] = t[7:0];
                        end
                        8'h2A, 8'h22, 8'h32: begin
                            if (op == 8'h2A) n_rf[IX_A] = w_rdata;
                            t = (op == 8'h32) ? w_hl - 16'd1 : w_hl + 16'd1;
                            n_rf[IX_H] = t[15:8]; n_rf[IX_L] = t[7:0];
                        end
                        8'h08: w_req = '{1'b1, 1'b1, nn + 16'd1, r_sp[15:8]};
                        8'hF5, 8'hC5, 8'hD5, 8'hE5: begin
                            case (op)
                                8'hF5: src = r_rf[IX_F];
                                8'hC5: src = r_rf[IX_C];
                                8'hD5: src = r_rf[IX_E];
                                default: src = r_rf[IX_L];
                            endcase
                            w_req = '{1'b1, 1'b1, r_sp - 16'd2, src};
                            n_sp = r_sp - 16'd2;
                        end
                        8'hF1, 8'hC1, 8'hD1, 8'hE1: begin
                            // Low byte arrived; fetch the high byte next.
                            dst = (op == 8'hF1) ? IX_F : (op == 8'hC1) ? IX_C :
                                  (op == 8'hD1) ? IX_E : IX_L;
                            n_rf[dst] = (op == 8'hF1) ? (w_rdata & 8'hF0) : w_rdata;
                            w_req = '{1'b1, 1'b0, r_sp + 16'd1, 8'd0};
                            n_sp = r_sp + 16'd1;
                            n_state = S_MEM3;
                        end
                        default: ;
                    endcase
                end
            end
            // High byte of a pop arrives here.
            S_MEM3: begin
                dst = (op == 8'hF1) ? IX_A : (op == 8'hC1) ? IX_B :
                      (op == 8'hD1) ? IX_D : IX_H;
                n_rf[dst] = w_rdata;
                n_sp = r_sp + 16'd1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (n_state == S_IDLE && r_state != S_IDLE && !w_ill) begin
            w_done = 1'b1;
            n_pc = r_pc + {14'd0, f_ops(op)} + 16'd1;
        end
        n_out = r_out; n_ov = r_ov && i_stall;
        if (w_done) begin
            n_ov = 1'b1;
            n_out.illegal_opcode = w_ill;
            n_out.read_data = w_rd;
            n_out.pc = n_pc; n_out.sp = n_sp;
            n_out.reg_af = {n_rf[IX_A], n_rf[IX_F]};
            n_out.reg_bc = {n_rf[IX_B], n_rf[IX_C]};
            n_out.reg_de = {n_rf[IX_D], n_rf[IX_E]};
            n_out.reg_hl = {n_rf[IX_H], n_rf[IX_L]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pc <= 16'd0; r_sp <= 16'd0;
            r_hostrd <= 1'b0; r_ov <= 1'b0;
            for (int k = 0; k < 8; k++) r_rf[k] <= 8'd0;
        end else begin
            r_state <= n_state; r_pc <= n_pc; r_sp <= n_sp;
            r_hostrd <= n_hostrd; r_ov <= n_ov;
            for (int k = 0; k < 8; k++) r_rf[k] <= n_rf[k];
        end
        r_op <= n_op; r_b1 <= n_b1; r_b2 <= n_b2; r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("input taken while busy");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("result dropped under stall");
    a_exec_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_data.cmd == CMD_EXEC) |=> (r_state == S_OP))
        else $error("execute did not start");
endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the load/store/stack executor: directed program
// table, then random instruction streams checked against a predictor.
// Depends on lsse_pkg and cpu_load_store_stack_executor_top.
`timescale 1ns / 1ps

module tb_top;
    import lsse_pkg::*;

    localparam int NUM_ITEMS = 1850;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;

    cpu_load_store_stack_executor_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Shadow CPU state.
    logic [7:0]  cpu_mem [65536];
    bit          mem_written [65536];
    logic [15:0] written_list [$];
    logic [7:0]  cpu_rf [8];
    logic [15:0] cpu_pc;
    logic [15:0] cpu_sp;

    t_out  pending_regs [$];
    int    n_errors;
    int    n_sent;
    int    n_exec;
    int    n_illegal;
    int    n_checked;
    bit    quiet;
    bit    hold_done;

    function automatic logic [15:0] get_pair(logic [2:0] hi, logic [2:0] lo);
        return {cpu_rf[hi], cpu_rf[lo]};
    endfunction

    task automatic set_pair(logic [2:0] hi, logic [2:0] lo, logic [15:0] v);
        cpu_rf[hi] = v[15:8];
        cpu_rf[lo] = v[7:0];
    endtask

    task automatic mem_store(logic [15:0] a, logic [7:0] v);
        if (!mem_written[a]) begin
            mem_written[a] = 1'b1;
            written_list.push_back(a);
        end
        cpu_mem[a] = v;
    endtask

    task automatic push_pair(logic [2:0] hi, logic [2:0] lo);
        cpu_sp = cpu_sp - 16'd1;
        mem_store(cpu_sp, cpu_rf[hi]);
        cpu_sp = cpu_sp - 16'd1;
        mem_store(cpu_sp, cpu_rf[lo]);
    endtask

    task automatic pop_pair(logic [2:0] hi, logic [2:0] lo);
        cpu_rf[lo] = cpu_mem[cpu_sp];
        cpu_sp = cpu_sp + 16'd1;
        cpu_rf[hi] = cpu_mem[cpu_sp];
        cpu_sp = cpu_sp + 16'd1;
    endtask

    // Executes the instruction at pc on the shadow state; ok is 0 for an
    // unsupported opcode, in which case nothing changes.
    task automatic run_instruction(output bit ok);
        logic [15:0] nn;
        logic [15:0] hl;
        logic [15:0] len;
        logic [7:0]  op;
        logic [7:0]  b1;
        logic [7:0]  v;
        op  = cpu_mem[cpu_pc];
        b1  = cpu_mem[cpu_pc + 16'd1];
        nn  = {cpu_mem[cpu_pc + 16'd2], b1};
        hl  = get_pair(IX_H, IX_L);
        len = 16'd1;
        ok  = 1'b1;
        if (op >= 8'h40 && op <= 8'h7F && op != 8'h76) begin
            v = (op[2:0] == 3'd6) ? cpu_mem[hl] : cpu_rf[op[2:0]];
            if (op[5:3] == 3'd6) mem_store(hl, v);
            else cpu_rf[op[5:3]] = v;
        end else if ((op & 8'hC7) == 8'h06) begin
            if (op[5:3] == 3'd6) mem_store(hl, b1);
            else cpu_rf[op[5:3]] = b1;
            len = 16'd2;
        end else begin
            case (op)
                8'h0A: cpu_rf[IX_A] = cpu_mem[get_pair(IX_B, IX_C)];
                8'h1A: cpu_rf[IX_A] = cpu_mem[get_pair(IX_D, IX_E)];
                8'hFA: begin cpu_rf[IX_A] = cpu_mem[nn]; len = 16'd3; end
                8'h02: mem_store(get_pair(IX_B, IX_C), cpu_rf[IX_A]);
                8'h12: mem_store(get_pair(IX_D, IX_E), cpu_rf[IX_A]);
                8'hEA: begin mem_store(nn, cpu_rf[IX_A]); len = 16'd3; end
                8'h01: begin set_pair(IX_B, IX_C, nn); len = 16'd3; end
                8'h11: begin set_pair(IX_D, IX_E, nn); len = 16'd3; end
                8'h21: begin set_pair(IX_H, IX_L, nn); len = 16'd3; end
                8'h31: begin cpu_sp = nn; len = 16'd3; end
                8'hF2: cpu_rf[IX_A] = cpu_mem[HIGH_PAGE | {8'd0, cpu_rf[IX_C]}];
                8'hE2: mem_store(HIGH_PAGE | {8'd0, cpu_rf[IX_C]}, cpu_rf[IX_A]);
                8'hF0: begin
                    cpu_rf[IX_A] = cpu_mem[HIGH_PAGE | {8'd0, b1}];
                    len = 16'd2;
                end
                8'hE0: begin
                    mem_store(HIGH_PAGE | {8'd0, b1}, cpu_rf[IX_A]);
                    len = 16'd2;
                end
                8'h3A: begin cpu_rf[IX_A] = cpu_mem[hl]; set_pair(IX_H, IX_L, hl - 16'd1); end
                8'h32: begin mem_store(hl, cpu_rf[IX_A]); set_pair(IX_H, IX_L, hl - 16'd1); end
                8'h2A: begin cpu_rf[IX_A] = cpu_mem[hl]; set_pair(IX_H, IX_L, hl + 16'd1); end
                8'h22: begin mem_store(hl, cpu_rf[IX_A]); set_pair(IX_H, IX_L, hl + 16'd1); end
                8'hF8: begin
                    // The offset is a signed byte; flags stay as they are.
                    set_pair(IX_H, IX_L, cpu_sp + {{8{b1[7]}}, b1});
                    len = 16'd2;
                end
                8'hF9: cpu_sp = hl;
                8'h08: begin
                    mem_store(nn, cpu_sp[7:0]);
                    mem_store(nn + 16'd1, cpu_sp[15:8]);
                    len = 16'd3;
                end
                8'hF5: push_pair(IX_A, IX_F);
                8'hC5: push_pair(IX_B, IX_C);
                8'hD5: push_pair(IX_D, IX_E);
                8'hE5: push_pair(IX_H, IX_L);
                8'hF1: begin
                    pop_pair(IX_A, IX_F);
                    cpu_rf[IX_F] = cpu_rf[IX_F] & 8'hF0;
                end
                8'hC1: pop_pair(IX_B, IX_C);
                8'hD1: pop_pair(IX_D, IX_E);
                8'hE1: pop_pair(IX_H, IX_L);
                8'h87: ;
                default: ok = 1'b0;
            endcase
        end
        if (ok) cpu_pc = cpu_pc + len;
    endtask

    task automatic step_cpu(t_in x, output t_out r);
        bit ok;
        r = '0;
        case (x.cmd)
            CMD_WRITE: mem_store(x.addr, x.data);
            CMD_READ:  r.read_data = cpu_mem[x.addr];
            CMD_EXEC: begin
                run_instruction(ok);
                r.illegal_opcode = !ok;
                n_exec++;
                if (!ok) n_illegal++;
            end
            default: ;
        endcase
        r.pc     = cpu_pc;
        r.sp     = cpu_sp;
        r.reg_af = get_pair(IX_A, IX_F);
        r.reg_bc = get_pair(IX_B, IX_C);
        r.reg_de = get_pair(IX_D, IX_E);
        r.reg_hl = get_pair(IX_H, IX_L);
    endtask

    // Offers one transfer and waits until it is taken. The valid stays high
    // into the next transfer unless an idle burst follows.
    task automatic send_item(t_in x, bit use_typed, t_out typed);
        t_out r;
        step_cpu(x, r);
        pending_regs.push_back(use_typed ? typed : r);
        i_valid <= 1'b1;
        i_data  <= x;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic host_write(logic [15:0] a, logic [7:0] d);
        t_in x;
        x.cmd  = CMD_WRITE;
        x.addr = a;
        x.data = d;
        send_item(x, 1'b0, '0);
    endtask

    task automatic fill_if_blank(logic [15:0] a);
        if (!mem_written[a]) host_write(a, 8'($urandom));
    endtask

    // Makes sure every byte the instruction will read holds a written value,
    // places the instruction at pc unless reusing what is there, then runs it.
    task automatic run_op(logic [7:0] op, logic [7:0] b1, logic [7:0] b2, bit reuse,
                          bit use_typed, t_out typed);
        t_in x;
        logic [15:0] hl;
        if (reuse) begin
            op = cpu_mem[cpu_pc];
            b1 = cpu_mem[cpu_pc + 16'd1];
            b2 = cpu_mem[cpu_pc + 16'd2];
        end
        hl = get_pair(IX_H, IX_L);
        if (op >= 8'h40 && op <= 8'h7F && op != 8'h76 && op[2:0] == 3'd6) fill_if_blank(hl);
        case (op)
            8'h0A: fill_if_blank(get_pair(IX_B, IX_C));
            8'h1A: fill_if_blank(get_pair(IX_D, IX_E));
            8'hFA: fill_if_blank({b2, b1});
            8'hF2: fill_if_blank(HIGH_PAGE | {8'd0, cpu_rf[IX_C]});
            8'hF0: fill_if_blank(HIGH_PAGE | {8'd0, b1});
            8'h3A, 8'h2A: fill_if_blank(hl);
            8'hF1, 8'hC1, 8'hD1, 8'hE1: begin
                fill_if_blank(cpu_sp);
                fill_if_blank(cpu_sp + 16'd1);
            end
            default: ;
        endcase
        if (!reuse) begin
            host_write(cpu_pc, op);
            host_write(cpu_pc + 16'd1, b1);
            host_write(cpu_pc + 16'd2, b2);
        end
        x.cmd  = CMD_EXEC;
        x.addr = 16'($urandom);
        x.data = 8'($urandom);
        send_item(x, use_typed, typed);
    endtask

    function automatic logic [7:0] pick_opcode();
        logic [7:0] known [30] = '{8'h0A, 8'h1A, 8'hFA, 8'h02, 8'h12, 8'hEA, 8'h01,
            8'h11, 8'h21, 8'h31, 8'hF2, 8'hE2, 8'hF0, 8'hE0, 8'h3A, 8'h32, 8'h2A,
            8'h22, 8'hF8, 8'hF9, 8'h08, 8'hF5, 8'hC5, 8'hD5, 8'hE5, 8'hF1, 8'hC1,
            8'hD1, 8'hE1, 8'h87};
        int r;
        logic [7:0] op;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            op = 8'($urandom_range(8'h40, 8'h7F));
            return (op == 8'h76) ? 8'h87 : op;
        end
        if (r < 50) return {2'b00, 3'($urandom), 3'd6};
        if (r < 93) return known[$urandom_range(0, 29)];
        return 8'($urandom);
    endfunction

    task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
        $display("ERROR at %0t: %s got %h expected %h", $time, field, got, want);
        n_errors++;
    endtask

    // Result side: every transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_regs.size() == 0) begin
                $display("ERROR at %0t: result with nothing expected", $time);
                n_errors++;
            end else begin
                want = pending_regs.pop_front();
                n_checked++;
                if (o_data.illegal_opcode !== want.illegal_opcode)
                    report_mismatch("illegal_opcode", 16'(o_data.illegal_opcode),
                                    16'(want.illegal_opcode));
                if (o_data.read_data !== want.read_data)
                    report_mismatch("read_data", 16'(o_data.read_data), 16'(want.read_data));
                if (o_data.pc !== want.pc) report_mismatch("pc", o_data.pc, want.pc);
                if (o_data.sp !== want.sp) report_mismatch("sp", o_data.sp, want.sp);
                if (o_data.reg_af !== want.reg_af)
                    report_mismatch("reg_af", o_data.reg_af, want.reg_af);
                if (o_data.reg_bc !== want.reg_bc)
                    report_mismatch("reg_bc", o_data.reg_bc, want.reg_bc);
                if (o_data.reg_de !== want.reg_de)
                    report_mismatch("reg_de", o_data.reg_de, want.reg_de);
                if (o_data.reg_hl !== want.reg_hl)
                    report_mismatch("reg_hl", o_data.reg_hl, want.reg_hl);
            end
        end
    end

    // Receiver stall: random bursts, one long hold-off so the block backs up,
    // and none near the end of the run.
    initial begin
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && n_sent > 600) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    typedef struct {
        logic [7:0] op;
        logic [7:0] b1;
        logic [7:0] b2;
        bit         use_typed;
        t_out       typed;
    } t_row;

    t_row program_rows [] = '{
        '{8'h3E, 8'hFF, 8'h00, 1'b1, '{1'b0, 8'h00, 16'h0002, 16'h0000, 16'hFF00,
                                       16'h0000, 16'h0000, 16'h0000}},
        '{8'h31, 8'hFE, 8'hFF, 1'b1, '{1'b0, 8'h00, 16'h0005, 16'hFFFE, 16'hFF00,
                                       16'h0000, 16'h0000, 16'h0000}},
        '{8'h76, 8'h00, 8'h00, 1'b1, '{1'b1, 8'h00, 16'h0005, 16'hFFFE, 16'hFF00,
                                       16'h0000, 16'h0000, 16'h0000}},
        '{8'hF5, 8'h00, 8'h00, 1'b0, '0},
        '{8'h01, 8'h34, 8'h12, 1'b0, '0},
        '{8'hC5, 8'h00, 8'h00, 1'b0, '0},
        '{8'hF1, 8'h00, 8'h00, 1'b0, '0},
        '{8'hD1, 8'h00, 8'h00, 1'b0, '0},
        '{8'h08, 8'h00, 8'hC0, 1'b0, '0},
        '{8'hF8, 8'h80, 8'h00, 1'b0, '0},
        '{8'hF8, 8'h7F, 8'h00, 1'b0, '0},
        '{8'hE2, 8'h00, 8'h00, 1'b0, '0},
        '{8'hF2, 8'h00, 8'h00, 1'b0, '0},
        '{8'hE0, 8'hFF, 8'h00, 1'b0, '0},
        '{8'hF0, 8'hFF, 8'h00, 1'b0, '0},
        '{8'h21, 8'hFF, 8'hFF, 1'b0, '0},
        '{8'h22, 8'h00, 8'h00, 1'b0, '0},
        '{8'h32, 8'h00, 8'h00, 1'b0, '0},
        '{8'h2A, 8'h00, 8'h00, 1'b0, '0},
        '{8'h3A, 8'h00, 8'h00, 1'b0, '0},
        '{8'hF9, 8'h00, 8'h00, 1'b0, '0},
        '{8'h87, 8'h00, 8'h00, 1'b0, '0},
        '{8'h76, 8'h00, 8'h00, 1'b0, '0}
    };

    initial begin
        t_in x;
        int  r;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_data    = '0;
        n_errors  = 0;
        n_sent    = 0;
        n_exec    = 0;
        n_illegal = 0;
        n_checked = 0;
        quiet     = 1'b0;
        hold_done = 1'b0;
        cpu_pc    = '0;
        cpu_sp    = '0;
        foreach (cpu_rf[k]) cpu_rf[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (program_rows[k])
            run_op(program_rows[k].op, program_rows[k].b1, program_rows[k].b2, 1'b0,
                   program_rows[k].use_typed, program_rows[k].typed);
        // Extreme addresses and data, a read back and the unused command.
        host_write(16'hFFFF, 8'hFF);
        host_write(16'h0000, 8'h00);
        x = '{CMD_READ, 16'hFFFF, 8'h00};
        send_item(x, 1'b0, '0);
        x = '{CMD_NONE, 16'hAAAA, 8'h55};
        send_item(x, 1'b0, '0);

        while (n_sent < NUM_ITEMS) begin
            if (n_sent > NUM_ITEMS - 250) quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 12) begin
                host_write(16'($urandom), 8'($urandom));
            end else if (r < 20) begin
                x = '{CMD_READ, written_list[$urandom_range(0, written_list.size() - 1)],
                      8'($urandom)};
                send_item(x, 1'b0, '0);
            end else if (r < 22) begin
                x = '{CMD_NONE, 16'($urandom), 8'($urandom)};
                send_item(x, 1'b0, '0);
            end else if (r < 30 && mem_written[cpu_pc] && mem_written[cpu_pc + 16'd1]
                         && mem_written[cpu_pc + 16'd2]) begin
                run_op(8'h00, 8'h00, 8'h00, 1'b1, 1'b0, '0);
            end else begin
                run_op(pick_opcode(), 8'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        while (pending_regs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Covered %0d transfers, %0d instructions (%0d unsupported), %0d results checked.",
                 n_sent, n_exec, n_illegal, n_checked);
        if (n_errors == 0 && pending_regs.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding.", pending_regs.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
